FILE: sv/tbo_pkg.sv
// ----------------------------------------------------------------------------
// tbo_pkg: shared constants and types
// Field widths, register codes, pipeline depth and the edge axis vertex pairs.
// ----------------------------------------------------------------------------
package tbo_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int HALF_WIDTH      = 31;
    localparam int INDEX_WIDTH     = 2;
    localparam int NUM_STAGES      = 9;

    typedef logic [INDEX_WIDTH-1:0] reg_index_t;

    localparam reg_index_t REG_HALF_X = 2'd0;
    localparam reg_index_t REG_HALF_Y = 2'd1;
    localparam reg_index_t REG_HALF_Z = 2'd2;

    typedef logic [1:0] vert_sel_t;

    // vertex pair projected on each edge cross axis: [edge][axis][pair member]
    localparam vert_sel_t EDGE_PAIR [3][3][2] = '{
        '{'{2'd0, 2'd2}, '{2'd0, 2'd2}, '{2'd1, 2'd2}},
        '{'{2'd0, 2'd2}, '{2'd0, 2'd2}, '{2'd0, 2'd1}},
        '{'{2'd0, 2'd1}, '{2'd0, 2'd1}, '{2'd1, 2'd2}}
    };

    // advance strobes of the edge axis stages: products, sums and compare
    typedef struct packed {
        logic prod;
        logic sum;
        logic cmp;
    } edge_adv_t;

endpackage

FILE: sv/tbo_if.sv
// ----------------------------------------------------------------------------
// tbo_req_if / tbo_res_if: request and result channels
// Valid/ready channels carrying one box/triangle pair and one overlap flag.
// ----------------------------------------------------------------------------
interface tbo_req_if #(
    parameter int CW = tbo_pkg::COORD_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] box_center_x;
    logic signed [CW-1:0] box_center_y;
    logic signed [CW-1:0] box_center_z;
    logic signed [CW-1:0] vert_a_x;
    logic signed [CW-1:0] vert_a_y;
    logic signed [CW-1:0] vert_a_z;
    logic signed [CW-1:0] vert_b_x;
    logic signed [CW-1:0] vert_b_y;
    logic signed [CW-1:0] vert_b_z;
    logic signed [CW-1:0] vert_c_x;
    logic signed [CW-1:0] vert_c_y;
    logic signed [CW-1:0] vert_c_z;

    modport source (
        output valid, box_center_x, box_center_y, box_center_z,
               vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
               vert_c_x, vert_c_y, vert_c_z,
        input  ready
    );
    modport sink (
        input  valid, box_center_x, box_center_y, box_center_z,
               vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
               vert_c_x, vert_c_y, vert_c_z,
        output ready
    );
endinterface

interface tbo_res_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink (input valid, overlap, output ready);
endinterface

FILE: sv/tbo_edge_axes.sv
// ----------------------------------------------------------------------------
// tbo_edge_axes: edge cross axis tests, every edge against every box axis
// Three stages: products, projection sums and radius, separation compare.
// ----------------------------------------------------------------------------
module tbo_edge_axes #(
    parameter int CW = tbo_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   clk,
    input  tbo_pkg::edge_adv_t                     adv,
    input  logic signed [CW+1:0]                   e [3][3],
    input  logic signed [CW:0]                     v [3][3],
    input  logic        [tbo_pkg::HALF_WIDTH-1:0]  h [3],
    output logic                                   sep
);
    localparam int VW = CW + 1;
    localparam int EW = CW + 2;
    localparam int HW = tbo_pkg::HALF_WIDTH;
    localparam int PW = EW + VW;
    localparam int RW = EW + HW + 1;
    localparam int XW = ((PW > RW) ? PW : RW) + 3;

    logic signed [PW-1:0] pa0_reg [3][3];
    logic signed [PW-1:0] pa1_reg [3][3];
    logic signed [PW-1:0] pb0_reg [3][3];
    logic signed [PW-1:0] pb1_reg [3][3];
    logic signed [RW-1:0] r0_reg  [3][3];
    logic signed [RW-1:0] r1_reg  [3][3];
    logic                 n0_reg  [3][3];
    logic                 n1_reg  [3][3];

    logic signed [XW-1:0] pa_reg [3][3];
    logic signed [XW-1:0] pb_reg [3][3];
    logic signed [XW-1:0] r_reg  [3][3];

    logic sep_reg;

    // products of the edge components with the vertices and half extents
    always_ff @(posedge clk)
    begin
        if (adv.prod)
        begin
            for (int t = 0; t < 3; t++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pa0_reg[t][k] <= e[t][(k+2)%3] * v[tbo_pkg::EDGE_PAIR[t][k][0]][(k+1)%3];
                    pa1_reg[t][k] <= e[t][(k+1)%3] * v[tbo_pkg::EDGE_PAIR[t][k][0]][(k+2)%3];
                    pb0_reg[t][k] <= e[t][(k+2)%3] * v[tbo_pkg::EDGE_PAIR[t][k][1]][(k+1)%3];
                    pb1_reg[t][k] <= e[t][(k+1)%3] * v[tbo_pkg::EDGE_PAIR[t][k][1]][(k+2)%3];
                    r0_reg[t][k]  <= e[t][(k+2)%3] * $signed({1'b0, h[(k+1)%3]});
                    r1_reg[t][k]  <= e[t][(k+1)%3] * $signed({1'b0, h[(k+2)%3]});
                    n0_reg[t][k]  <= e[t][(k+2)%3][EW-1];
                    n1_reg[t][k]  <= e[t][(k+1)%3][EW-1];
                end
            end
        end
    end

    // projections and radius; a negative edge component flips its radius term
    always_ff @(posedge clk)
    begin
        if (adv.sum)
        begin
            for (int t = 0; t < 3; t++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pa_reg[t][k] <= XW'(pa0_reg[t][k]) - XW'(pa1_reg[t][k]);
                    pb_reg[t][k] <= XW'(pb0_reg[t][k]) - XW'(pb1_reg[t][k]);
                    r_reg[t][k]  <= (n0_reg[t][k] ? -XW'(r0_reg[t][k]) : XW'(r0_reg[t][k]))
                                  + (n1_reg[t][k] ? -XW'(r1_reg[t][k]) : XW'(r1_reg[t][k]));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.cmp)
        begin
            logic any;
            any = 1'b0;
            for (int t = 0; t < 3; t++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if ((pa_reg[t][k] > r_reg[t][k] && pb_reg[t][k] > r_reg[t][k]) ||
                        (pa_reg[t][k] < -r_reg[t][k] && pb_reg[t][k] < -r_reg[t][k]))
                    begin
                        any = 1'b1;
                    end
                end
            end
            sep_reg <= any;
        end
    end

    assign sep = sep_reg;

endmodule

FILE: sv/triangle_box_overlap_test.sv
// Throughput: one request per cycle while the result is taken; a 9-stage pipeline with a valid bit per stage.
// A stalled result holds only the stages behind it that are full; bubbles collapse.
// Reset clears all stage valid bits and loads each half extent with 0.5.
// The user must keep the half extents static while requests are in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
// triangle_box_overlap_test: triangle against axis-aligned box overlap
// Separating axis test over box faces, triangle plane and the cross axes of
// every edge with every box axis, in exact fixed point.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test #(
    parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tbo_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tbo_req_if.sink                           request,
    tbo_res_if.source                         result,
    input  logic                              wr_en,
    input  tbo_pkg::reg_index_t               wr_index,
    input  logic [tbo_pkg::HALF_WIDTH-1:0]    wr_data
);
    localparam int CW  = COORD_WIDTH;
    localparam int VW  = CW + 1;
    localparam int EW  = CW + 2;
    localparam int HW  = tbo_pkg::HALF_WIDTH;
    localparam int NS  = tbo_pkg::NUM_STAGES;
    localparam int NW  = 2 * EW + 1;
    localparam int SL  = NW / 2;
    localparam int SH  = NW - SL;
    localparam int NVW = NW + VW + 1;
    localparam int NHW = NW + HW + 2;
    localparam int PLW = NW + VW + HW + 4;
    localparam int FW  = VW + HW + 2;
    localparam logic [HW-1:0] HALF_RESET = HW'((64'd1 << FRAC_BITS) >> 1);

    // ------------------------------------------------------------------
    // configuration: half extents
    // ------------------------------------------------------------------
    logic [HW-1:0] half_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                half_reg[k] <= HALF_RESET;
            end
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tbo_pkg::REG_HALF_X: half_reg[0] <= wr_data;
                tbo_pkg::REG_HALF_Y: half_reg[1] <= wr_data;
                tbo_pkg::REG_HALF_Z: half_reg[2] <= wr_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control: a stage advances when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic [NS:1] vld_reg;
    logic [NS:1] vld_next;
    logic [NS:1] adv;

    always_comb
    begin
        adv[NS] = !vld_reg[NS] || result.ready;
        for (int s = NS - 1; s >= 1; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
        vld_next[1] = adv[1] ? request.valid : vld_reg[1];
        for (int s = 2; s <= NS; s++)
        begin
            vld_next[s] = adv[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign request.ready = adv[1];

    // ------------------------------------------------------------------
    // stage 1: vertices relative to the box center
    // ------------------------------------------------------------------
    logic signed [CW-1:0] pin [3][3];
    logic signed [CW-1:0] cin [3];
    logic signed [VW-1:0] v1_reg [3][3];

    always_comb
    begin
        cin[0] = request.box_center_x;
        cin[1] = request.box_center_y;
        cin[2] = request.box_center_z;
        pin[0][0] = request.vert_a_x;
        pin[0][1] = request.vert_a_y;
        pin[0][2] = request.vert_a_z;
        pin[1][0] = request.vert_b_x;
        pin[1][1] = request.vert_b_y;
        pin[1][2] = request.vert_b_z;
        pin[2][0] = request.vert_c_x;
        pin[2][1] = request.vert_c_y;
        pin[2][2] = request.vert_c_z;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int t = 0; t < 3; t++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    v1_reg[t][k] <= VW'(pin[t][k]) - VW'(cin[k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: edges and box face tests
    // ------------------------------------------------------------------
    logic signed [EW-1:0] e2_reg [3][3];
    logic signed [VW-1:0] v2_reg [3][3];
    logic                 face2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            logic                 fsep;
            logic signed [FW-1:0] hs;
            fsep = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                hs = $signed(FW'({1'b0, half_reg[k]}));
                if ((FW'(v1_reg[0][k]) > hs && FW'(v1_reg[1][k]) > hs &&
                     FW'(v1_reg[2][k]) > hs) ||
                    (FW'(v1_reg[0][k]) < -hs && FW'(v1_reg[1][k]) < -hs &&
                     FW'(v1_reg[2][k]) < -hs))
                begin
                    fsep = 1'b1;
                end
                e2_reg[0][k] <= EW'(v1_reg[1][k]) - EW'(v1_reg[0][k]);
                e2_reg[1][k] <= EW'(v1_reg[2][k]) - EW'(v1_reg[1][k]);
                e2_reg[2][k] <= EW'(v1_reg[0][k]) - EW'(v1_reg[2][k]);
            end
            v2_reg    <= v1_reg;
            face2_reg <= fsep;
        end
    end

    // ------------------------------------------------------------------
    // stages 3 to 5: edge cross axes in their own unit
    // ------------------------------------------------------------------
    tbo_pkg::edge_adv_t edge_adv;
    logic               edge5_sep;

    assign edge_adv = '{prod: adv[3], sum: adv[4], cmp: adv[5]};

    tbo_edge_axes #(
        .CW (CW)
    ) u_edge (
        .clk (clk),
        .adv (edge_adv),
        .e   (e2_reg),
        .v   (v2_reg),
        .h   (half_reg),
        .sep (edge5_sep)
    );

    // ------------------------------------------------------------------
    // stages 3 to 8: triangle plane against the box
    // ------------------------------------------------------------------
    logic signed [2*EW-1:0] pn0_reg [3];
    logic signed [2*EW-1:0] pn1_reg [3];
    logic signed [VW-1:0]   v03_reg [3];
    logic                   face3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pn0_reg[k] <= e2_reg[0][(k+1)%3] * e2_reg[1][(k+2)%3];
                pn1_reg[k] <= e2_reg[0][(k+2)%3] * e2_reg[1][(k+1)%3];
                v03_reg[k] <= v2_reg[0][k];
            end
            face3_reg <= face2_reg;
        end
    end

    // normal
    logic signed [NW-1:0] n4_reg [3];
    logic signed [VW-1:0] v04_reg [3];
    logic                 face4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int k = 0; k < 3; k++)
            begin
                n4_reg[k]  <= NW'(pn0_reg[k]) - NW'(pn1_reg[k]);
                v04_reg[k] <= v03_reg[k];
            end
            face4_reg <= face3_reg;
        end
    end

    // split the normal into a low unsigned and a high signed half; multiply each by the vertex and half extent
    logic signed [SL+VW:0]   pvl5_reg [3];
    logic signed [SH+VW-1:0] pvh5_reg [3];
    logic signed [SL+HW+1:0] phl5_reg [3];
    logic signed [SH+HW:0]   phh5_reg [3];
    logic                    neg5_reg [3];
    logic                    face5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pvl5_reg[k] <= $signed({1'b0, n4_reg[k][SL-1:0]}) * v04_reg[k];
                pvh5_reg[k] <= $signed(n4_reg[k][NW-1:SL]) * v04_reg[k];
                phl5_reg[k] <= $signed({1'b0, n4_reg[k][SL-1:0]})
                             * $signed({1'b0, half_reg[k]});
                phh5_reg[k] <= $signed(n4_reg[k][NW-1:SL]) * $signed({1'b0, half_reg[k]});
                neg5_reg[k] <= n4_reg[k][NW-1];
            end
            face5_reg <= face4_reg;
        end
    end

    // recombine the halves
    logic signed [NVW-1:0] nv6_reg [3];
    logic signed [NHW-1:0] nh6_reg [3];
    logic                  neg6_reg [3];
    logic                  sep6_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            for (int k = 0; k < 3; k++)
            begin
                nv6_reg[k]  <= (NVW'(pvh5_reg[k]) <<< SL) + NVW'(pvl5_reg[k]);
                nh6_reg[k]  <= (NHW'(phh5_reg[k]) <<< SL) + NHW'(phl5_reg[k]);
                neg6_reg[k] <= neg5_reg[k];
            end
            sep6_reg <= face5_reg || edge5_sep;
        end
    end

    // dot product with the first vertex; magnitude of each normal term
    logic signed [PLW-1:0] dot7_reg;
    logic signed [PLW-1:0] ta7_reg [3];
    logic                  sep7_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            dot7_reg <= PLW'(nv6_reg[0]) + PLW'(nv6_reg[1]) + PLW'(nv6_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                ta7_reg[k] <= neg6_reg[k] ? -PLW'(nh6_reg[k]) : PLW'(nh6_reg[k]);
            end
            sep7_reg <= sep6_reg;
        end
    end

    // box radius along the normal
    logic signed [PLW-1:0] dot8_reg;
    logic signed [PLW-1:0] rad8_reg;
    logic                  sep8_reg;

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            dot8_reg <= dot7_reg;
            rad8_reg <= ta7_reg[0] + ta7_reg[1] + ta7_reg[2];
            sep8_reg <= sep7_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: plane verdict and output register
    // near corner above the plane: dot + rad < 0; far corner below: rad < dot
    // ------------------------------------------------------------------
    logic overlap9_reg;
    logic plane_sep;

    assign plane_sep = ((dot8_reg + rad8_reg) < 0) || (rad8_reg < dot8_reg);

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            overlap9_reg <= !(sep8_reg || plane_sep);
        end
    end

    assign result.valid   = vld_reg[NS];
    assign result.overlap = overlap9_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> vld_reg[1])
        else $error("accepted request did not enter stage 1");

    a_stall_holds_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[8] && !adv[8]) |=> ($stable(rad8_reg) && $stable(dot8_reg)))
        else $error("stalled plane sums changed");

    a_no_drop_under_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS] && !result.ready && vld_reg[NS-1]) |=> vld_reg[NS-1])
        else $error("full stage lost its request under stall");

    a_separated_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (adv[9] && vld_reg[8] && sep8_reg) |=> !result.overlap)
        else $error("separating axis found but overlap reported");

endmodule
